// ----- rtl/fingerprint_packet_deframer_macros.svh -----
// Assertion macros for the fingerprint packet deframer.
`ifndef FINGERPRINT_PACKET_DEFRAMER_MACROS_SVH
`define FINGERPRINT_PACKET_DEFRAMER_MACROS_SVH

// Implication checked at every clock edge, off during reset.
`define FPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fpd assertion failed");

// Condition that must never hold, off during reset.
`define FPD_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("fpd forbidden condition seen");

`endif

// ----- rtl/fpd_pkg.sv -----
// Shared constants and types for the fingerprint packet deframer.
package fpd_pkg;

    localparam logic [3:0] HEADER_BYTES  = 4'd9;
    localparam logic [3:0] HDR_POS_SYNC0 = 4'd0;
    localparam logic [3:0] HDR_POS_SYNC1 = 4'd1;
    localparam logic [3:0] HDR_POS_ID    = 4'd6;
    localparam logic [3:0] HDR_POS_LENHI = 4'd7;
    localparam logic [3:0] HDR_POS_LENLO = 4'd8;

    localparam logic [7:0]  SYNC_FIRST  = 8'hEF;
    localparam logic [7:0]  SYNC_SECOND = 8'h01;
    localparam logic [7:0]  END_ID      = 8'h08;
    localparam logic [23:0] TOTAL_MAX   = 24'hFFFFFF;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef struct packed {
        logic [15:0] packet_number;
        logic [23:0] packet_offset;
        logic [16:0] packet_bytes;
        logic        header_valid;
        logic        is_end_packet;
        logic        is_target;
        logic [23:0] total_bytes;
    } t_result;

    typedef struct packed {
        logic        stopped;
        logic [15:0] packet_count;
        logic [3:0]  hdr_pos;
    } t_core_status;

endpackage

// ----- rtl/fpd_if.sv -----
// Valid/ready channel interfaces for the deframer's byte input and packet report output.
interface fpd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface fpd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] packet_number;
    logic [23:0] packet_offset;
    logic [16:0] packet_bytes;
    logic        header_valid;
    logic        is_end_packet;
    logic        is_target;
    logic [23:0] total_bytes;

    modport source (output valid, output packet_number, output packet_offset,
                    output packet_bytes, output header_valid, output is_end_packet,
                    output is_target, output total_bytes, input ready);
    modport sink   (input valid, input packet_number, input packet_offset,
                    input packet_bytes, input header_valid, input is_end_packet,
                    input is_target, input total_bytes, output ready);
endinterface

// ----- rtl/fpd_core.sv -----
// Framing state, counters and packet report computation, one byte per cycle while i_accept is high.
module fpd_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_accept,
    input  logic                 i_kind,
    input  logic [7:0]           i_data_byte,
    output logic                 o_emit,
    output fpd_pkg::t_result     o_result,
    output fpd_pkg::t_core_status o_status
);

    logic [15:0] r_target;
    logic [3:0]  r_hdr_pos, n_hdr_pos;
    logic [15:0] r_remaining, n_remaining;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [7:0]  r_id, n_id;
    logic        r_good, n_good;
    logic [15:0] r_count, n_count;
    logic [23:0] r_total, n_total;
    logic        r_stopped, n_stopped;

    logic        emit;
    logic        is_end;
    logic [16:0] plen;
    logic [24:0] sum;
    logic [23:0] sum_sat;

    always_comb begin
        n_hdr_pos   = r_hdr_pos;
        n_remaining = r_remaining;
        n_len_hi    = r_len_hi;
        n_len_lo    = r_len_lo;
        n_id        = r_id;
        n_good      = r_good;
        n_count     = r_count;
        n_total     = r_total;
        n_stopped   = r_stopped;
        emit        = 1'b0;

        if (i_accept) begin
            if (i_kind == fpd_pkg::KIND_START) begin
                n_hdr_pos   = '0;
                n_remaining = '0;
                n_count     = '0;
                n_total     = '0;
                n_good      = 1'b1;
                n_stopped   = 1'b0;
            end else if (!r_stopped) begin
                if (r_hdr_pos < fpd_pkg::HEADER_BYTES) begin
                    case (r_hdr_pos)
                        fpd_pkg::HDR_POS_SYNC0: n_good = (i_data_byte == fpd_pkg::SYNC_FIRST);
                        fpd_pkg::HDR_POS_SYNC1: begin
                            if (i_data_byte != fpd_pkg::SYNC_SECOND) begin
                                n_good = 1'b0;
                            end
                        end
                        fpd_pkg::HDR_POS_ID:    n_id     = i_data_byte;
                        fpd_pkg::HDR_POS_LENHI: n_len_hi = i_data_byte;
                        default: ;
                    endcase
                    if (r_hdr_pos == fpd_pkg::HDR_POS_LENLO) begin
                        n_len_lo    = i_data_byte;
                        n_remaining = {r_len_hi, i_data_byte};
                        n_hdr_pos   = fpd_pkg::HEADER_BYTES;
                        // empty payload: packet ends on its last header byte
                        emit        = ({r_len_hi, i_data_byte} == 16'd0);
                    end else begin
                        n_hdr_pos = r_hdr_pos + 4'd1;
                    end
                end else begin
                    if (r_remaining != 16'd0) begin
                        n_remaining = r_remaining - 16'd1;
                    end
                    emit = (r_remaining <= 16'd1);
                end
            end
        end

        plen    = {1'b0, r_len_hi, n_len_lo} + 17'(fpd_pkg::HEADER_BYTES);
        sum     = {1'b0, r_total} + {8'd0, plen};
        sum_sat = sum[24] ? fpd_pkg::TOTAL_MAX : sum[23:0];
        is_end  = r_good && (r_id == fpd_pkg::END_ID);

        if (emit) begin
            n_total     = sum_sat;
            n_count     = r_count + 16'd1;
            n_hdr_pos   = '0;
            n_remaining = '0;
            if (!r_good || is_end) begin
                n_stopped = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_hdr_pos   <= '0;
            r_remaining <= '0;
            r_len_hi    <= '0;
            r_len_lo    <= '0;
            r_id        <= '0;
            r_good      <= 1'b1;
            r_count     <= '0;
            r_total     <= '0;
            r_stopped   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_data;
            end
            r_hdr_pos   <= n_hdr_pos;
            r_remaining <= n_remaining;
            r_len_hi    <= n_len_hi;
            r_len_lo    <= n_len_lo;
            r_id        <= n_id;
            r_good      <= n_good;
            r_count     <= n_count;
            r_total     <= n_total;
            r_stopped   <= n_stopped;
        end
    end

    assign o_emit                 = emit;
    assign o_result.packet_number = r_count;
    assign o_result.packet_offset = r_total;
    assign o_result.packet_bytes  = plen;
    assign o_result.header_valid  = r_good;
    assign o_result.is_end_packet = is_end;
    assign o_result.is_target     = (r_count == r_target);
    assign o_result.total_bytes   = sum_sat;

    assign o_status.stopped      = r_stopped;
    assign o_status.packet_count = r_count;
    assign o_status.hdr_pos      = r_hdr_pos;

endmodule

// ----- rtl/fpd_out_buf.sv -----
// Two-entry result buffer that decouples the core from output backpressure.
module fpd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fpd_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output fpd_pkg::t_result o_data,
    output logic             o_full,
    output logic [1:0]       o_count
);

    fpd_pkg::t_result r_entry [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_entry[r_rd_ptr];
    assign o_count = r_count;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/fingerprint_packet_deframer.sv -----
// Fingerprint packet deframer top level: byte input, packet reports out.
// Takes one item per clock while input ready is high: a received byte or a
// start marker. Framing counters update in the same cycle the item is
// accepted; a finished report goes into a two-entry output buffer and is
// registered there before the sink sees it. Input ready drops only while
// both buffer entries hold reports that the sink has not taken. The user
// must write target_index through i_cfg_we/i_cfg_data only while idle;
// the block does not enforce this.
`include "fingerprint_packet_deframer_macros.svh"

module fingerprint_packet_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    fpd_in_if.sink      i_in,
    fpd_out_if.source   o_out
);

    logic                  accept;
    logic                  emit;
    logic                  buf_full;
    logic                  buf_valid;
    logic [1:0]            buf_count;
    fpd_pkg::t_result      core_result;
    fpd_pkg::t_result      buf_data;
    fpd_pkg::t_core_status core_status;

    assign i_in.ready = !buf_full;
    assign accept     = i_in.valid && !buf_full;

    fpd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_kind      (i_in.kind),
        .i_data_byte (i_in.data_byte),
        .o_emit      (emit),
        .o_result    (core_result),
        .o_status    (core_status)
    );

    fpd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_data  (core_result),
        .i_pop   (o_out.ready),
        .o_valid (buf_valid),
        .o_data  (buf_data),
        .o_full  (buf_full),
        .o_count (buf_count)
    );

    assign o_out.valid         = buf_valid;
    assign o_out.packet_number = buf_data.packet_number;
    assign o_out.packet_offset = buf_data.packet_offset;
    assign o_out.packet_bytes  = buf_data.packet_bytes;
    assign o_out.header_valid  = buf_data.header_valid;
    assign o_out.is_end_packet = buf_data.is_end_packet;
    assign o_out.is_target     = buf_data.is_target;
    assign o_out.total_bytes   = buf_data.total_bytes;

    `FPD_NEVER(a_buf_overflow, i_clk, i_rst_n, (buf_count == 2'd3) || (emit && buf_full))
    `FPD_ASSERT(a_start_clears, i_clk, i_rst_n,
        (accept && i_in.kind == fpd_pkg::KIND_START) |=>
            (core_status.packet_count == 16'd0 && !core_status.stopped &&
             core_status.hdr_pos == 4'd0))
    `FPD_ASSERT(a_stop_after_final, i_clk, i_rst_n,
        (emit && (!core_result.header_valid || core_result.is_end_packet)) |=>
            core_status.stopped)
    `FPD_ASSERT(a_total_covers_offset, i_clk, i_rst_n,
        o_out.valid |-> (o_out.total_bytes >= o_out.packet_offset))

endmodule
